@@ rtl/sdpq_pkg.sv @@
// Shared constants, codes and control/status types for the sorted dedup priority queue.
// No dependencies; used by sdpq_ctrl, sdpq_dp and the top level.
`timescale 1ns / 1ps

package sdpq_pkg;

  localparam int DEPTH        = 16;
  localparam int VALUE_BITS   = 16;
  localparam int VALUE_W      = 16;
  localparam int STATUS_W     = 2;
  localparam int ITEM_COUNT_W = 5;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int IDX_W        = $clog2(DEPTH);

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    load_req;
    logic    rd_top;
    logic    probe;
    logic    step;
    logic    wr_ins_hi;
    logic    wr_ins_lo;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    take_pull;
    logic    set_status;
    status_e status;
    logic    load_out;
  } cmd_t;

  // datapath flags seen by the controller
  typedef struct packed {
    logic is_pull;
    logic cnt_zero;
    logic cnt_full;
    logic idx_zero;
    logic gt;
    logic eq;
  } dp_sts_t;

endpackage

@@ rtl/sdpq_ctrl.sv @@
// Request sequencer for the sorted dedup priority queue.
// Depends on sdpq_pkg; drives sdpq_dp through cmd_t and reads dp_sts_t.
`timescale 1ns / 1ps

module sdpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sdpq_pkg::dp_sts_t sts_i,
  output sdpq_pkg::cmd_t    cmd_o
);
  import sdpq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_START = 7'b0000010,
    S_FIND  = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_PLACE = 7'b0010000,
    S_PULL  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.status = ST_OK;
    in_ready_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d = S_START;
        end
      end
      S_START: begin
        cmd_o.set_status = 1'b1;
        if (sts_i.is_pull) begin
          if (sts_i.cnt_zero) begin
            cmd_o.status = ST_EMPTY;
            state_d = S_FIN;
          end else begin
            cmd_o.rd_top = 1'b1;
            state_d = S_PULL;
          end
        end else if (sts_i.cnt_full) begin
          cmd_o.status = ST_FULL;
          state_d = S_FIN;
        end else if (sts_i.cnt_zero) begin
          cmd_o.wr_ins_lo = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
          state_d = S_FIN;
        end else begin
          cmd_o.rd_top = 1'b1;
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        // read-only walk down from the top looking for a held value
        if (sts_i.eq) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status     = ST_DUP;
          state_d = S_FIN;
        end else if (sts_i.gt && !sts_i.idx_zero) begin
          cmd_o.probe = 1'b1;
        end else begin
          cmd_o.rd_top = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // walk down from the top, moving larger entries up one place
        if (sts_i.gt) begin
          cmd_o.step = 1'b1;
          if (sts_i.idx_zero) begin
            state_d = S_PLACE;
          end
        end else begin
          cmd_o.wr_ins_hi = 1'b1;
          cmd_o.cnt_inc   = 1'b1;
          state_d = S_FIN;
        end
      end
      S_PLACE: begin
        cmd_o.wr_ins_lo = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        state_d = S_FIN;
      end
      S_PULL: begin
        cmd_o.take_pull = 1'b1;
        cmd_o.cnt_dec   = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/sdpq_dp.sv @@
// Datapath of the sorted dedup priority queue: entry memory, count, scan index, result word.
// Depends on sdpq_pkg; controlled by sdpq_ctrl through cmd_t.
`timescale 1ns / 1ps

module sdpq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_type_i,
  input  logic [sdpq_pkg::VALUE_W-1:0]        value_i,
  input  sdpq_pkg::cmd_t                      cmd_i,
  output sdpq_pkg::dp_sts_t                   sts_o,
  output logic [sdpq_pkg::VALUE_W-1:0]        pulled_value_o,
  output logic [sdpq_pkg::STATUS_W-1:0]       status_o,
  output logic [sdpq_pkg::ITEM_COUNT_W-1:0]   item_count_o,
  output logic                                is_empty_o
);
  import sdpq_pkg::*;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rdata_q;

  logic                  type_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [IDX_W-1:0]      idx_q;
  logic [VALUE_BITS-1:0] pulled_q;
  status_e               status_q;

  logic [VALUE_W-1:0]      out_pulled_q;
  status_e                 out_status_q;
  logic [ITEM_COUNT_W-1:0] out_count_q;

  logic [IDX_W-1:0]      top_idx;
  logic [IDX_W-1:0]      idx_up;
  logic [IDX_W-1:0]      raddr;
  logic                  rd_en;
  logic [IDX_W-1:0]      waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic                  wr_en;

  assign top_idx = IDX_W'(cnt_q - 1'b1);
  assign idx_up  = idx_q + 1'b1;

  assign sts_o.is_pull  = (type_q == REQ_PULL);
  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.cnt_full = (cnt_q == CNT_W'(DEPTH));
  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.gt       = (rdata_q > val_q);
  assign sts_o.eq       = (rdata_q == val_q);

  always_comb begin
    rd_en = 1'b0;
    raddr = top_idx;
    if (cmd_i.rd_top) begin
      rd_en = 1'b1;
    end else if ((cmd_i.step || cmd_i.probe) && (idx_q != '0)) begin
      rd_en = 1'b1;
      raddr = idx_q - 1'b1;
    end
  end

  always_comb begin
    wr_en = cmd_i.step | cmd_i.wr_ins_hi | cmd_i.wr_ins_lo;
    waddr = idx_up;
    wdata = val_q;
    if (cmd_i.step) begin
      wdata = rdata_q;
    end else if (cmd_i.wr_ins_lo) begin
      waddr = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem[raddr];
    end
  end

  // request, scan index and result payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      type_q   <= req_type_i;
      val_q    <= value_i[VALUE_BITS-1:0];
      pulled_q <= '0;
      status_q <= ST_OK;
    end else begin
      if (cmd_i.take_pull) begin
        pulled_q <= rdata_q;
      end
      if (cmd_i.set_status) begin
        status_q <= cmd_i.status;
      end
    end
    if (cmd_i.rd_top) begin
      idx_q <= top_idx;
    end else if (cmd_i.step || cmd_i.probe) begin
      idx_q <= idx_q - 1'b1;
    end
    if (cmd_i.load_out) begin
      out_pulled_q <= VALUE_W'(pulled_q);
      out_status_q <= status_q;
      out_count_q  <= ITEM_COUNT_W'(cnt_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (cmd_i.cnt_dec) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign pulled_value_o = out_pulled_q;
  assign status_o       = out_status_q;
  assign item_count_o   = out_count_q;
  assign is_empty_o     = (out_count_q == '0);

endmodule

@@ rtl/sorted_dedup_priority_queue.sv @@
// Top level of the sorted dedup priority queue: sequencer plus datapath.
// Depends on sdpq_pkg, sdpq_ctrl and sdpq_dp.
//
//   channel | handshake               | word
//   --------+-------------------------+---------------------------------------------
//   in      | in_valid_i / in_ready_o | req_type_i, value_i
//   out     | out_valid_o/out_ready_i | pulled_value_o, status_o, item_count_o,
//           |                         | is_empty_o
//
// one request at a time; a refused add, an empty pull or a first entry goes straight from
// the start state to the result, a pull reads the top entry and takes it; an add scans down
// once from the top for a held value, then again from the top moving larger entries up
// reset clears the count and handshake state; the entry memory needs no clearing
// a new request is taken while the result waits; a stalled output holds the last step
`timescale 1ns / 1ps

module sorted_dedup_priority_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [sdpq_pkg::VALUE_W-1:0]       value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sdpq_pkg::VALUE_W-1:0]       pulled_value_o,
  output logic [sdpq_pkg::STATUS_W-1:0]      status_o,
  output logic [sdpq_pkg::ITEM_COUNT_W-1:0]  item_count_o,
  output logic                               is_empty_o
);
  import sdpq_pkg::*;

  cmd_t    cmd;
  dp_sts_t sts;

  sdpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sdpq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .pulled_value_o (pulled_value_o),
    .status_o       (status_o),
    .item_count_o   (item_count_o),
    .is_empty_o     (is_empty_o)
  );

endmodule

@@ sim/tb_sorted_dedup_priority_queue.sv @@
// Self-checking testbench for sorted_dedup_priority_queue: directed and random add/pull
// traffic, checked word by word against an in-bench sorted-array model of the queue.
// Depends on sdpq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_sorted_dedup_priority_queue;
  import sdpq_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [VALUE_W-1:0]      pulled;
    status_e                 status;
    logic [ITEM_COUNT_W-1:0] count;
    logic                    empty;
  } outcome_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    req_type_i;
  logic [VALUE_W-1:0]      value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [VALUE_W-1:0]      pulled_value_o;
  logic [STATUS_W-1:0]     status_o;
  logic [ITEM_COUNT_W-1:0] item_count_o;
  logic                    is_empty_o;

  // model of the queue contents, ascending in places 0 .. model_count-1
  logic [VALUE_W-1:0] model_entries [DEPTH];
  int                 model_count = 0;
  outcome_t           awaited_words [$];

  int mismatches   = 0;
  int quiet_cycles = 0;
  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  bit hold_output    = 1'b0;

  sorted_dedup_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pulled_value_o (pulled_value_o),
    .status_o       (status_o),
    .item_count_o   (item_count_o),
    .is_empty_o     (is_empty_o)
  );

  always #5 clk_i = ~clk_i;

  // applies one request to the model and returns the word the block must produce
  function automatic outcome_t queue_outcome(logic req, logic [VALUE_W-1:0] val);
    outcome_t           o;
    logic [VALUE_W-1:0] v;
    int                 pos;
    int                 i;
    v = val & VALUE_W'((64'd1 << VALUE_BITS) - 64'd1);
    o.pulled = '0;
    if (req == REQ_ADD) begin
      // full check comes before the duplicate search
      if (model_count >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        o.status = ST_OK;
        pos = model_count;
        for (i = 0; i < model_count; i++) begin
          if (model_entries[i] == v) begin
            o.status = ST_DUP;
            break;
          end
          if (model_entries[i] > v) begin
            pos = i;
            break;
          end
        end
        if (o.status == ST_OK) begin
          for (i = model_count; i > pos; i--) model_entries[i] = model_entries[i-1];
          model_entries[pos] = v;
          model_count++;
        end
      end
    end else if (model_count == 0) begin
      o.status = ST_EMPTY;
    end else begin
      model_count--;
      o.pulled = model_entries[model_count];
      o.status = ST_OK;
    end
    o.count = ITEM_COUNT_W'(model_count);
    o.empty = (model_count == 0);
    return o;
  endfunction

  // mix of held values (duplicates), small values, top-end values and full-range values
  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 4))
      0: v = (model_count > 0) ? model_entries[$urandom_range(0, model_count - 1)]
                               : VALUE_W'($urandom);
      1: v = VALUE_W'($urandom_range(0, 31));
      2: v = {VALUE_W{1'b1}} - VALUE_W'($urandom_range(0, 15));
      default: v = VALUE_W'($urandom);
    endcase
    return v;
  endfunction

  // offers one word, returns at the edge where it is accepted
  task automatic offer_request(input logic req, input logic [VALUE_W-1:0] val);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    awaited_words.push_back(queue_outcome(req, val));
  endtask

  task automatic random_requests(input int count);
    int n;
    int add_pct;
    for (n = 0; n < count; n++) begin
      // alternate the add bias so the count sweeps between empty and full
      add_pct = ((n / 48) % 2) ? 30 : 75;
      offer_request(($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_PULL, pick_value());
    end
  endtask

  task automatic test_empty_pull();
    offer_request(REQ_PULL, 16'hA5A5);
  endtask

  task automatic test_extremes_and_dups();
    offer_request(REQ_ADD, 16'h0000);
    offer_request(REQ_ADD, 16'hFFFF);
    offer_request(REQ_ADD, 16'h5555);
    offer_request(REQ_ADD, 16'hAAAA);
    offer_request(REQ_ADD, 16'h0000);
    offer_request(REQ_ADD, 16'hFFFF);
  endtask

  task automatic test_fill_to_full();
    logic [VALUE_W-1:0] fill_vals [12] = '{16'h1234, 16'h0100, 16'h7FFF, 16'h8001,
                                           16'h0002, 16'hC000, 16'h4000, 16'h00FF,
                                           16'hFFFE, 16'h0001, 16'h8000, 16'h5556};
    int i;
    for (i = 0; i < 12; i++) offer_request(REQ_ADD, fill_vals[i]);
    // refused when full, a held value too
    offer_request(REQ_ADD, 16'h3333);
    offer_request(REQ_ADD, 16'h5555);
    offer_request(REQ_PULL, 16'h0000);
    offer_request(REQ_PULL, 16'hFFFF);
  endtask

  task automatic test_random_traffic();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    random_requests(560);
  endtask

  task automatic test_output_backpressure();
    sender_idles = 1'b0;
    hold_output  = 1'b1;
    random_requests(40);
    sender_idles = 1'b1;
  endtask

  task automatic test_streaming();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    random_requests(480);
  endtask

  // receiver: random stall bursts, and one long hold-off on request
  initial begin : result_sink
    int n;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
        out_ready_i <= 1'b1;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 9);
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_words
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: pulled %h status %0d count %0d empty %0b",
                   pulled_value_o, status_o, item_count_o, is_empty_o);
      end else begin
        want = awaited_words.pop_front();
        if (pulled_value_o !== want.pulled || status_o !== want.status ||
            item_count_o !== want.count || is_empty_o !== want.empty) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected pulled %h status %0d count %0d empty %0b, %s",
                     want.pulled, want.status, want.count, want.empty,
                     $sformatf("got pulled %h status %0d count %0d empty %0b",
                               pulled_value_o, status_o, item_count_o, is_empty_o));
        end
      end
    end
  end

  // quiet-cycle watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    req_type_i <= REQ_ADD;
    value_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_pull();
    test_extremes_and_dups();
    test_fill_to_full();
    test_random_traffic();
    test_output_backpressure();
    test_streaming();

    in_valid_i <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
